### design/ffe_pkg.sv
package ffe_pkg;

  // Grid geometry
  localparam int GRID_WIDTH   = 24;
  localparam int VISIBLE_ROWS = 24;
  localparam int SEED_WIDTH   = 24;
  localparam int COORD_W      = 5;
  localparam int HEAT_W       = 8;

  // Stored rows are 0 .. VISIBLE_ROWS; the seed row lives only in the row line.
  localparam int RAM_DEPTH = (VISIBLE_ROWS + 1) * GRID_WIDTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int ROW_W     = $clog2(VISIBLE_ROWS + 1);
  localparam int COL_W     = $clog2(GRID_WIDTH);

  localparam logic [ROW_W-1:0]  ROW_FIRST = ROW_W'(VISIBLE_ROWS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(GRID_WIDTH - 1);
  localparam logic [HEAT_W-1:0] HEAT_HOT  = 8'd255;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef struct packed {
    logic load;      // capture request fields, arm frame counters
    logic adv_step;  // issue one cell of the frame walk
    logic rd_issue;  // issue the grid read for a read request
    logic out_load;  // fill the output register
  } ctl_t;

  typedef struct packed {
    logic last_cell;  // walk is at row 0, last column
    logic pipe_busy;  // a cell write is in flight
  } sts_t;

  // Fire palette: eight 32-step segments, returns {ch0, ch1, ch2}.
  function automatic logic [23:0] pal_lookup(input logic [HEAT_W-1:0] h);
    logic [4:0] s;
    logic [7:0] s2;
    logic [7:0] s8;
    logic [7:0] s1;
    logic [23:0] rgb;
    s   = h[4:0];
    s2  = {2'b00, s, 1'b0};
    s8  = {s, 3'b000};
    s1  = {3'b000, s};
    rgb = '0;
    case (h[7:5])
      3'd0:    rgb = {8'd0, 8'd0, s2};
      3'd1:    rgb = {8'd0, s8, 8'd64 - s2};
      3'd2:    rgb = {s8, 8'd255, 8'd0};
      3'd3:    rgb = {8'd255, 8'd255, s2};
      3'd4:    rgb = {8'd255, 8'd255, 8'd64 + s2};
      3'd5:    rgb = {8'd255, 8'd255, 8'd128 + s2};
      3'd6:    rgb = {8'd255, 8'd255, 8'd192 + s1};
      3'd7:    rgb = {8'd255, 8'd255, 8'd224 + s1};
      default: rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

### design/ffe_ram.sv
module ffe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 600
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ffe_ctrl.sv
module ffe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          command_i,
  input  logic          out_ready_i,
  input  ffe_pkg::sts_t st_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output ffe_pkg::ctl_t ctl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = (command_i == ffe_pkg::CMD_READ) ? S_RD : S_ADV;
        end
      end
      S_ADV: begin
        ctl_o.adv_step = 1'b1;
        if (st_i.last_cell) begin
          state_d = S_FIN;
        end
      end
      S_RD: begin
        ctl_o.rd_issue = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/ffe_datapath.sv
module ffe_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ffe_pkg::ctl_t                       ctl_i,
  output ffe_pkg::sts_t                       st_o,
  input  logic                                command_i,
  input  logic [ffe_pkg::SEED_WIDTH-1:0]      seed_bits_i,
  input  logic [ffe_pkg::COORD_W-1:0]         cell_x_i,
  input  logic [ffe_pkg::COORD_W-1:0]         cell_y_i,
  output logic                                frame_done_o,
  output logic [ffe_pkg::HEAT_W-1:0]          heat_value_o,
  output logic [ffe_pkg::HEAT_W-1:0]          colour_a_o,
  output logic [ffe_pkg::HEAT_W-1:0]          colour_b_o,
  output logic [ffe_pkg::HEAT_W-1:0]          colour_c_o
);

  localparam int W = ffe_pkg::GRID_WIDTH;

  // Request capture
  logic                           cmd_q;
  logic [ffe_pkg::COORD_W-1:0]    cx_q, cy_q;

  // Frame walk counters (issue side)
  logic [ffe_pkg::ROW_W-1:0]      row_q, row_d;
  logic [ffe_pkg::COL_W-1:0]      col_q, col_d;

  // Write side, in the cycle after issue
  logic                           pipe_vld_q;
  logic [ffe_pkg::ROW_W-1:0]      pipe_row_q;
  logic [ffe_pkg::COL_W-1:0]      pipe_col_q;
  logic [ffe_pkg::ADDR_W-1:0]     pipe_addr_q;

  // Row line: line_q[0] is the below cell of the cell being written
  logic [ffe_pkg::HEAT_W-1:0]     line_q [W];
  logic [ffe_pkg::HEAT_W-1:0]     left_q;

  // Grid has been written by at least one full frame
  logic                           primed_q;

  logic [W+ffe_pkg::SEED_WIDTH-1:0] seed_ext;
  logic [ffe_pkg::ADDR_W-1:0]     cell_addr, rd_addr, raddr;
  logic [ffe_pkg::HEAT_W-1:0]     rdata;
  logic                           rd_in_range;
  logic [ffe_pkg::HEAT_W-1:0]     t_below, t_left, t_right, t_self;
  logic [11:0]                    sum;
  logic [ffe_pkg::HEAT_W-1:0]     avg, new_heat;
  logic [ffe_pkg::HEAT_W-1:0]     heat_sel;
  logic [23:0]                    rgb;

  assign seed_ext = {{W{1'b0}}, seed_bits_i};

  assign cell_addr   = ffe_pkg::ADDR_W'(32'(row_q) * 32'(W) + 32'(col_q));
  assign rd_in_range = (32'(cx_q) < 32'(W)) && (32'(cy_q) < 32'(ffe_pkg::VISIBLE_ROWS));
  assign rd_addr     = rd_in_range ?
                       ffe_pkg::ADDR_W'(32'(cy_q) * 32'(W) + 32'(cx_q)) : '0;
  assign raddr       = ctl_i.adv_step ? cell_addr : rd_addr;

  // Next walk position: columns left to right, rows bottom up
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (ctl_i.load) begin
      row_d = ffe_pkg::ROW_FIRST;
      col_d = '0;
    end else if (ctl_i.adv_step) begin
      if (col_q == ffe_pkg::COL_LAST) begin
        col_d = '0;
        row_d = row_q - 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign st_o.last_cell = (row_q == '0) && (col_q == ffe_pkg::COL_LAST);
  assign st_o.pipe_busy = pipe_vld_q;

  // Cell kernel
  assign t_below = line_q[0];
  assign t_right = (pipe_col_q != ffe_pkg::COL_LAST) ? line_q[1] : '0;
  assign t_left  = (pipe_col_q != '0) ? left_q : '0;
  assign t_self  = (pipe_row_q != '0 && primed_q) ? rdata : '0;

  assign sum = {2'b00, t_below, 2'b00} + {3'b000, t_left, 1'b0}
             + {3'b000, t_right, 1'b0} + {1'b0, t_self, 3'b000};
  assign avg      = sum[11:4];
  assign new_heat = (avg > 8'd1) ? avg - 8'd1 : avg;

  ffe_ram #(
    .WIDTH(ffe_pkg::HEAT_W),
    .DEPTH(ffe_pkg::RAM_DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (pipe_vld_q),
    .waddr_i(pipe_addr_q),
    .wdata_i(new_heat),
    .re_i   (ctl_i.adv_step | ctl_i.rd_issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Read result
  assign heat_sel = (cmd_q == ffe_pkg::CMD_READ && rd_in_range && primed_q) ? rdata : '0;
  assign rgb      = ffe_pkg::pal_lookup(heat_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= 1'b0;
      primed_q   <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      pipe_vld_q <= ctl_i.adv_step;
      row_q      <= row_d;
      col_q      <= col_d;
      if (ctl_i.out_load && cmd_q == ffe_pkg::CMD_ADVANCE) begin
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= command_i;
      cx_q  <= cell_x_i;
      cy_q  <= cell_y_i;
    end
    if (ctl_i.adv_step) begin
      pipe_row_q  <= row_q;
      pipe_col_q  <= col_q;
      pipe_addr_q <= cell_addr;
    end
    if (ctl_i.load) begin
      for (int i = 0; i < W; i++) begin
        line_q[i] <= seed_ext[i] ? ffe_pkg::HEAT_HOT : '0;
      end
    end else if (pipe_vld_q) begin
      left_q <= line_q[0];
      for (int i = 0; i < W - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
      line_q[W-1] <= new_heat;
    end
    if (ctl_i.out_load) begin
      frame_done_o <= (cmd_q == ffe_pkg::CMD_ADVANCE);
      heat_value_o <= heat_sel;
      colour_a_o   <= rgb[23:16];
      colour_b_o   <= rgb[15:8];
      colour_c_o   <= rgb[7:0];
    end
  end

endmodule

### design/fire_effect_frame_engine.sv
// Fire effect frame engine. Holds a heat grid of 26 rows by 24 columns (one seed
// row, one hidden row, 24 visible rows) and a fixed 256-entry fire palette. An
// advance request loads the seed row from seed_bits_i and rebuilds rows 24..0
// bottom up, one cell per cycle: the row just built sits in a 24-entry shift
// line that feeds the next row's below, below-left and below-right taps, while
// the single grid RAM (600 x 8, one write and one registered read port) gives
// the old value of each cell and takes the new one in the next cycle. An
// advance is worked as an accept step, a walk over all 600 cells and a closing
// step in which the last write drains while the result is loaded; a read is
// worked as accept, RAM read and result. One request is worked at a time; a
// new one is taken as soon as the previous result sits in the output register,
// even if that result is not yet taken. The grid is not cleared after reset: a
// flag marks it empty until the first advance completes, and until then all
// stored cells read as zero.
module fire_effect_frame_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [ffe_pkg::SEED_WIDTH-1:0]      seed_bits_i,
  input  logic [ffe_pkg::COORD_W-1:0]         cell_x_i,
  input  logic [ffe_pkg::COORD_W-1:0]         cell_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                frame_done_o,
  output logic [ffe_pkg::HEAT_W-1:0]          heat_value_o,
  output logic [ffe_pkg::HEAT_W-1:0]          colour_a_o,
  output logic [ffe_pkg::HEAT_W-1:0]          colour_b_o,
  output logic [ffe_pkg::HEAT_W-1:0]          colour_c_o
);

  ffe_pkg::ctl_t ctl;
  ffe_pkg::sts_t st;

  // Sequencer: idle / frame walk / grid read / result hand-off
  ffe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .ctl_o      (ctl)
  );

  // Grid RAM, row line, cell kernel, palette and output register
  ffe_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .st_o        (st),
    .command_i   (command_i),
    .seed_bits_i (seed_bits_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .frame_done_o(frame_done_o),
    .heat_value_o(heat_value_o),
    .colour_a_o  (colour_a_o),
    .colour_b_o  (colour_b_o),
    .colour_c_o  (colour_c_o)
  );

  // An accepted advance keeps the input closed while the frame is walked.
  a_adv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == ffe_pkg::CMD_ADVANCE) |=> !in_ready_o)
    else $error("input reopened right after an advance request");

  // No request may slip in while a cell write is still in flight.
  a_no_accept_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.pipe_busy |-> !in_ready_o)
    else $error("input open during a grid write");

  // A frame-done result carries no heat or colour.
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |->
      (heat_value_o == '0 && colour_a_o == '0 && colour_b_o == '0 && colour_c_o == '0))
    else $error("frame-done result carries read data");

endmodule
